// ===== hdl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and constants shared by the Huffman code bit packer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int unsigned SymbolCount   = 256;
  localparam int unsigned SymAddrWidth  = $clog2(SymbolCount);
  localparam int unsigned CodeWidth     = 15;
  localparam int unsigned LenWidth      = 4;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KindLoad   = 2'd0,
    KindEncode = 2'd1,
    KindFlush  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           symbol;
    logic [CodeWidth-1:0] code_bits;
    logic [LenWidth-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [LenWidth-1:0]  len;
    logic [CodeWidth-1:0] code;
  } code_entry_t;

  // Bytes handed from the packer to the output queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

`default_nettype wire

// ===== hdl/huffman_code_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Huffman encoder back end: code table, bit accumulator and byte output.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_item_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (out_item_t)
//
// One item per cycle enters while in_ready_o is high; the code table read registers
// at the transfer edge, and the merge and byte split then write the bytes into the
// queue register once the queue has room for a two byte run. Output drains one byte a
// cycle while out_ready_i is high, through a four byte queue; input stalls while an item
// waits and the queue cannot take a two byte run. Reset clears the accumulator and
// the queue; table entries are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_core
  import hcbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  code_entry_t code_table [SymbolCount];
  code_entry_t rd_entry_q;
  logic        s1_valid_q;
  logic [1:0]  s1_kind_q;
  logic        in_acc;
  logic        space;
  push_t       push;

  assign in_ready_o = !s1_valid_q || space;
  assign in_acc     = in_valid_i && in_ready_o;

  // Load writes and encode reads share the transfer edge; a later read sees
  // any earlier write, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (in_data_i.kind == KindLoad) begin
        code_table[in_data_i.symbol[SymAddrWidth-1:0]] <=
          '{len: in_data_i.code_length, code: in_data_i.code_bits};
      end
      rd_entry_q <= code_table[in_data_i.symbol[SymAddrWidth-1:0]];
      s1_kind_q  <= in_data_i.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  hcbp_packer u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid_q),
    .advance_i (space),
    .kind_i    (s1_kind_q),
    .entry_i   (rd_entry_q),
    .push_o    (push)
  );

  hcbp_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !space) |=> (s1_valid_q && $stable(s1_kind_q)))
    else $error("stalled stage lost its item");

  a_push_when_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count != 2'd0) |-> (s1_valid_q && space))
    else $error("bytes pushed without an advancing item");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_kind_q == KindLoad) |-> (push.count == 2'd0))
    else $error("load produced output");

endmodule

`default_nettype wire

// ===== hdl/hcbp_packer.sv =====
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit accumulator: merges a code into the pending bits and splits off bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_packer
  import hcbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        advance_i,
  input  logic [1:0]  kind_i,
  input  code_entry_t entry_i,
  output push_t       push_o
);

  localparam int unsigned WinWidth = 8 + CodeWidth;

  logic [7:0]           pend_bits_q, pend_bits_d;
  logic [2:0]           pend_cnt_q, pend_cnt_d;
  logic [CodeWidth-1:0] code_masked;
  logic [4:0]           total;
  logic [4:0]           shift;
  logic [WinWidth-1:0]  window;
  logic [1:0]           nbytes;

  // Window: pending bits at the top, new code right behind them.
  always_comb begin
    code_masked = entry_i.code & ~({CodeWidth{1'b1}} << entry_i.len);
    total       = {2'b0, pend_cnt_q} + {1'b0, entry_i.len};
    shift       = 5'(WinWidth) - total;
    window      = {pend_bits_q, {CodeWidth{1'b0}}}
                | ({{8{1'b0}}, code_masked} << shift);
    nbytes      = total[4:3];
  end

  always_comb begin
    push_o      = '0;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    unique case (kind_i)
      KindEncode: begin
        push_o.count              = nbytes;
        push_o.first.out_byte     = window[WinWidth-1 -: 8];
        push_o.first.last_of_run  = (nbytes == 2'd1);
        push_o.second.out_byte    = window[WinWidth-9 -: 8];
        push_o.second.last_of_run = 1'b1;
        pend_cnt_d                = total[2:0];
        priority case (nbytes)
          2'd0:    pend_bits_d = window[WinWidth-1 -: 8];
          2'd1:    pend_bits_d = window[WinWidth-9 -: 8];
          default: pend_bits_d = {window[WinWidth-17 -: 7], 1'b0};
        endcase
      end
      KindFlush: begin
        push_o.count             = (pend_cnt_q != 3'd0) ? 2'd1 : 2'd0;
        push_o.first.out_byte    = pend_bits_q;
        push_o.first.last_of_run = 1'b1;
        pend_bits_d              = '0;
        pend_cnt_d               = '0;
      end
      default: ;
    endcase
    // Push only on the cycle the item advances.
    if (!valid_i || !advance_i) begin
      push_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else if (valid_i && advance_i) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

  // Unused low pending bits stay zero.
  a_pend_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_cnt_q == 3'd0) |-> (pend_bits_q == 8'd0))
    else $error("pending bits not cleared with empty accumulator");

  a_two_bytes_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (!push_o.first.last_of_run && push_o.second.last_of_run))
    else $error("last marker misplaced on a two byte run");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && advance_i && kind_i == KindFlush) |=> (pend_cnt_q == 3'd0))
    else $error("flush left bits pending");

endmodule

`default_nettype wire

// ===== hdl/hcbp_out_queue.sv =====
// ----------------------------------------------------------------------------
// hcbp_out_queue
// Small shifting byte queue: takes up to two bytes a cycle, gives one while out_ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_out_queue
  import hcbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  out_item_t                entry_q [QueueDepth];
  out_item_t                entry_d [QueueDepth];
  logic [QueueCntWidth-1:0] cnt_q, cnt_d;
  logic [QueueCntWidth-1:0] cnt_kept;
  logic                     pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = entry_q[0];
  // Room for a two byte run, whatever is popped this cycle.
  assign space_o     = (cnt_q <= QueueCntWidth'(QueueDepth - 2));

  always_comb begin
    cnt_kept = cnt_q - QueueCntWidth'(pop);
    for (int i = 0; i < QueueDepth; i++) begin
      if (pop && i < QueueDepth - 1) begin
        entry_d[i] = entry_q[i+1];
      end else begin
        entry_d[i] = entry_q[i];
      end
      if (push_i.count != 2'd0 && QueueCntWidth'(i) == cnt_kept) begin
        entry_d[i] = push_i.first;
      end
      if (push_i.count == 2'd2 &&
          QueueCntWidth'(i) == cnt_kept + QueueCntWidth'(1)) begin
        entry_d[i] = push_i.second;
      end
    end
    cnt_d = cnt_kept + QueueCntWidth'(push_i.count);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntWidth'(QueueDepth))
    else $error("output queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> space_o)
    else $error("bytes pushed without room");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count == 2'd0 && !pop) |=> $stable(cnt_q))
    else $error("queue count moved without a transfer");

endmodule

`default_nettype wire
